/* src/rcar_pkg.sv */
// ----------------------------------------------------------------------------
// rcar_pkg: shared types and constants of the RMS current amplitude regulator
// Q16.16 fixed-point constants, item and configuration structs, sequencer
// states and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rcar_pkg;

    localparam int DW   = 32;            // data word width
    localparam int FB   = 16;            // fraction bits
    localparam int IW   = 64;            // integral width
    localparam int QW   = 50;            // gain * |error| width
    localparam int C_ONE = 1 << FB;
    localparam int C_HI  = ((11 << FB) + 5) / 10;   // 1.1 in Q16.16
    localparam int C_LO  = ((9 << FB) + 5) / 10;    // 0.9 in Q16.16

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_INIT_AMP = 3'd0,
        CFG_FREQ     = 3'd1,
        CFG_PERIOD   = 3'd2,
        CFG_TARGET   = 3'd3,
        CFG_GAIN     = 3'd4,
        CFG_TOL      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [DW-1:0] init_amp;
        logic [DW-1:0] freq;
        logic [DW-1:0] period;
        logic [DW-1:0] target;
        logic [16:0]   gain;
        logic [22:0]   tol;
    } t_cfg;

    typedef struct packed {
        logic [DW-1:0]        time_step;
        logic [DW-1:0]        current_sq_sample;
        logic signed [DW-1:0] power_sample;
        logic                 first_step;
    } t_item;

    // queue status and pop as driven by the back end
    typedef struct packed {
        logic avail;
        logic pop;
    } t_q_ctl;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MC, ST_MP, ST_ACC, ST_CHK,
        ST_F0, ST_F1, ST_F2, ST_F3,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_SQW,
        ST_D0, ST_D1, ST_D2, ST_DIV, ST_AM, ST_AM2, ST_EMIT
    } t_state;

endpackage

`default_nettype wire

/* src/rms_current_amplitude_regulator_core.sv */
// ----------------------------------------------------------------------------
// rms_current_amplitude_regulator_core: RMS current amplitude regulator
// Integrates current and power per tick; at a period end outside the deadband
// it corrects the drive amplitude toward a target RMS. Q16.16 throughout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one tick item; a two-entry
//   queue lets ticks arrive while the back end works. Output channel
//   (o_out_valid / i_out_stall) returns exactly one result per tick from an
//   output register. Configuration writes (i_cfg_valid / o_cfg_ready, always
//   ready) go to registers 0..5; other indexes are ignored.
//   Sequencing: an ordinary tick passes the states IDLE, MC, MP, ACC, CHK and
//   EMIT. A period end adds the 32-step square root when the RMS is inside
//   the deadband, and the 50-step divider as well when the amplitude is
//   corrected. One tick is processed at a time.
//   Reset clears the integrals, previous samples, elapsed time and amplitude,
//   empties the queue and drops any pending result; config returns to defaults.
//   When the receiver stalls, the result holds and the sequencer waits after
//   finishing the next tick; the input queue keeps filling until full.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_current_amplitude_regulator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tick items
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [rcar_pkg::DW-1:0]        i_time_step,
    input  logic [rcar_pkg::DW-1:0]        i_current_sq_sample,
    input  logic signed [rcar_pkg::DW-1:0] i_power_sample,
    input  logic                           i_first_step,
    // results
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [rcar_pkg::DW-1:0]        o_amplitude,
    output logic                           o_period_done,
    output logic [rcar_pkg::DW-1:0]        o_rms_current,
    output logic signed [rcar_pkg::DW-1:0] o_average_power,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [2:0]                     i_cfg_index,
    input  logic [rcar_pkg::DW-1:0]        i_cfg_data
);
    import rcar_pkg::*;

    t_cfg   r_cfg;
    t_item  w_in_item, w_q_item;
    t_q_ctl w_q_ctl;
    logic   w_avail;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_amp <= DW'(65536);
            r_cfg.freq     <= DW'(65536);
            r_cfg.period   <= DW'(65536);
            r_cfg.target   <= DW'(65536);
            r_cfg.gain     <= 17'd6554;
            r_cfg.tol      <= 23'd65536;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_INIT_AMP: r_cfg.init_amp <= i_cfg_data;
                CFG_FREQ:     r_cfg.freq     <= i_cfg_data;
                CFG_PERIOD:   r_cfg.period   <= i_cfg_data;
                CFG_TARGET:   r_cfg.target   <= i_cfg_data;
                CFG_GAIN:     r_cfg.gain     <= i_cfg_data[16:0];
                CFG_TOL:      r_cfg.tol      <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    assign w_in_item.time_step         = i_time_step;
    assign w_in_item.current_sq_sample = i_current_sq_sample;
    assign w_in_item.power_sample      = i_power_sample;
    assign w_in_item.first_step        = i_first_step;

    rcar_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (w_in_item),
        .i_pop      (w_q_ctl.pop),
        .o_avail    (w_avail),
        .o_item     (w_q_item)
    );

    rcar_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item          (w_q_item),
        .i_avail         (w_avail),
        .o_q_ctl         (w_q_ctl),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_amplitude     (o_amplitude),
        .o_period_done   (o_period_done),
        .o_rms_current   (o_rms_current),
        .o_average_power (o_average_power)
    );

    // ---- assertions ----
    // results outside a period end carry no RMS or power figure
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_period_done |-> o_rms_current == '0 && o_average_power == '0)
        else $error("period fields set without period end");

    // reset drops any pending result
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // the back end only takes an item that the queue holds
    a_pop_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_ctl.pop |-> w_q_ctl.avail)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

/* src/rcar_front.sv */
// ----------------------------------------------------------------------------
// rcar_front: input side of the regulator
// Accepts tick items and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rcar_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  rcar_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_avail,
    output rcar_pkg::t_item o_item
);
    import rcar_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_in_stall = (r_cnt == 2'd2);
    assign o_avail    = (r_cnt != 2'd0);
    assign o_item     = r_mem[r_rp];
    assign w_push     = i_in_valid && !o_in_stall;

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            if (w_push && !i_pop)      r_cnt <= r_cnt + 2'd1;
            else if (!w_push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end

endmodule

`default_nettype wire

/* src/rcar_sqrt.sv */
// ----------------------------------------------------------------------------
// rcar_sqrt: iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcar_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_busy,
    output logic [31:0] o_root
);
    logic [63:0] r_x;
    logic [32:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [34:0] w_sh;
    logic [34:0] w_trial;
    logic        w_ge;

    assign w_sh    = {r_rem, r_x[63:62]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_sh >= w_trial);
    assign o_busy  = r_busy;
    assign o_root  = r_root;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) r_busy <= 1'b0;
        end
    end

    // one root bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= 33'd0;
            r_root <= 32'd0;
        end else if (r_busy) begin
            r_x    <= {r_x[61:0], 2'b00};
            r_rem  <= w_ge ? 33'(w_sh - w_trial) : w_sh[32:0];
            r_root <= {r_root[30:0], w_ge};
        end
    end

endmodule

`default_nettype wire

/* src/rcar_div.sv */
// ----------------------------------------------------------------------------
// rcar_div: iterative unsigned divider
// Restoring division of a 50-bit dividend by a 32-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcar_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [rcar_pkg::QW-1:0]  i_dividend,
    input  logic [rcar_pkg::DW-1:0]  i_divisor,
    output logic                     o_busy,
    output logic [rcar_pkg::QW-1:0]  o_quot
);
    import rcar_pkg::*;

    logic [QW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic [DW:0]   w_sh;
    logic          w_ge;

    assign w_sh   = {r_rem, r_q[QW-1]};
    assign w_ge   = (w_sh >= {1'b0, r_d});
    assign o_busy = r_busy;
    assign o_quot = r_q;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'(QW - 1)) r_busy <= 1'b0;
        end
    end

    // shift-subtract step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? DW'(w_sh - {1'b0, r_d}) : w_sh[DW-1:0];
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

/* src/rcar_back.sv */
// ----------------------------------------------------------------------------
// rcar_back: tick processing of the regulator
// Sequencer around one shared 33x33 multiplier: trapezoid integration, period
// end (RMS via square root unit, average power), deadband test and amplitude
// correction via the divider. Ends in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcar_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rcar_pkg::t_cfg               i_cfg,
    input  rcar_pkg::t_item              i_item,
    input  logic                         i_avail,
    output rcar_pkg::t_q_ctl             o_q_ctl,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [rcar_pkg::DW-1:0]      o_amplitude,
    output logic                         o_period_done,
    output logic [rcar_pkg::DW-1:0]      o_rms_current,
    output logic signed [rcar_pkg::DW-1:0] o_average_power
);
    import rcar_pkg::*;

    localparam logic signed [IW:0] P_MAX = {2'b00, {(IW-1){1'b1}}};
    localparam logic signed [IW:0] P_MIN = -P_MAX;

    t_state r_state, n_state;

    // tick fields
    logic [DW-1:0]        r_dt, r_cs;
    logic signed [DW-1:0] r_ps;
    logic                 r_first;
    // regulator state
    logic [IW-1:0]        r_ci;
    logic signed [IW-1:0] r_pi;
    logic [DW-1:0]        r_pcs;
    logic signed [DW-1:0] r_pps;
    logic [DW-1:0]        r_el;
    logic [DW-1:0]        r_amp;
    // working registers
    logic [65:0]          r_prod;
    logic [95:0]          r_acc;
    logic                 r_sneg;
    logic                 r_rms_sat;
    logic [DW-1:0]        r_rms;
    logic [DW-1:0]        r_avg;
    logic signed [DW:0]   r_e;
    logic [DW:0]          r_ae;
    logic [16:0]          r_fac;
    logic                 r_done;
    // output register
    logic                 r_ovalid;
    logic [DW-1:0]        r_o_amp, r_o_rms, r_o_avg;
    logic                 r_o_done;

    logic [32:0]          w_mul_a, w_mul_b;
    logic                 w_pop, w_sq_start, w_div_start, w_emit;
    logic                 w_sq_busy, w_div_busy;
    logic [31:0]          w_sq_root;
    logic [QW-1:0]        w_quot;
    logic [DW:0]          w_sum_cs;
    logic signed [DW:0]   w_sp;
    logic [DW:0]          w_sp_mag;
    logic [IW:0]          w_ci_sum;
    logic signed [IW:0]   w_pi_ext, w_pi_add;
    logic [48:0]          w_inc;
    logic [DW:0]          w_el_sum;
    logic [IW-2:0]        w_pmag;
    logic [79:0]          w_m;
    logic signed [DW:0]   w_e;
    logic [DW:0]          w_rt_sum;
    logic [55:0]          w_lhs;
    logic                 w_out_band;
    logic [DW-1:0]        w_divisor;

    // ---- datapath helpers ----
    assign w_sum_cs = {1'b0, r_cs} + {1'b0, r_pcs};
    assign w_sp     = {r_ps[DW-1], r_ps} + {r_pps[DW-1], r_pps};
    assign w_sp_mag = w_sp[DW] ? (DW+1)'(-w_sp) : w_sp;
    assign w_inc    = r_prod[65:17];
    assign w_ci_sum = {1'b0, r_ci} + (IW+1)'(w_inc);
    assign w_pi_ext = {r_pi[IW-1], r_pi};
    assign w_pi_add = r_sneg ? w_pi_ext - $signed((IW+1)'(w_inc))
                             : w_pi_ext + $signed((IW+1)'(w_inc));
    assign w_el_sum = {1'b0, r_el} + {1'b0, r_dt};
    assign w_pmag   = r_pi[IW-1] ? (IW-1)'(-r_pi) : r_pi[IW-2:0];
    assign w_m      = r_acc[95:16];
    assign w_e      = $signed({1'b0, r_rms}) - $signed({1'b0, i_cfg.target});
    assign w_rt_sum = {1'b0, r_rms} + {1'b0, i_cfg.target};
    assign w_lhs    = (56'(r_ae) * 56'd200) << FB;
    assign w_out_band = (w_lhs > r_prod[55:0]);
    assign w_divisor  = (i_cfg.target != '0) ? i_cfg.target : DW'(1);

    // ---- control outputs ----
    always_comb begin
        w_pop       = (r_state == ST_IDLE) && i_avail;
        w_sq_start  = (r_state == ST_F3);
        w_div_start = (r_state == ST_D2);
        w_emit      = (r_state == ST_EMIT) && (!r_ovalid || !i_out_stall);
    end

    assign o_q_ctl.avail = i_avail;
    assign o_q_ctl.pop   = w_pop;

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_avail) n_state = ST_MC;
            ST_MC:   n_state = ST_MP;
            ST_MP:   n_state = ST_ACC;
            ST_ACC:  n_state = ST_CHK;
            ST_CHK:  n_state = (r_el >= i_cfg.period) ? ST_F0 : ST_EMIT;
            ST_F0:   n_state = ST_F1;
            ST_F1:   n_state = ST_F2;
            ST_F2:   n_state = ST_F3;
            ST_F3:   n_state = ST_P0;
            ST_P0:   n_state = ST_P1;
            ST_P1:   n_state = ST_P2;
            ST_P2:   n_state = ST_P3;
            ST_P3:   n_state = ST_SQW;
            ST_SQW:  if (!w_sq_busy) n_state = ST_D0;
            ST_D0:   n_state = ST_D1;
            ST_D1:   n_state = w_out_band ? ST_D2 : ST_EMIT;
            ST_D2:   n_state = ST_DIV;
            ST_DIV:  if (!w_div_busy) n_state = ST_AM;
            ST_AM:   n_state = ST_AM2;
            ST_AM2:  n_state = ST_EMIT;
            ST_EMIT: if (w_emit) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- shared multiplier operands ----
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_MC: begin w_mul_a = w_sum_cs;                w_mul_b = {1'b0, r_dt};         end
            ST_MP: begin w_mul_a = w_sp_mag;                w_mul_b = {1'b0, r_dt};         end
            ST_F0: begin w_mul_a = {1'b0, r_ci[31:0]};      w_mul_b = {1'b0, i_cfg.freq};   end
            ST_F1: begin w_mul_a = {1'b0, r_ci[63:32]};     w_mul_b = {1'b0, i_cfg.freq};   end
            ST_P0: begin w_mul_a = {1'b0, w_pmag[31:0]};    w_mul_b = {1'b0, i_cfg.freq};   end
            ST_P1: begin w_mul_a = {2'b00, w_pmag[62:32]};  w_mul_b = {1'b0, i_cfg.freq};   end
            ST_D0: begin w_mul_a = w_rt_sum;                w_mul_b = 33'(i_cfg.tol);       end
            ST_D1: begin w_mul_a = r_ae;                    w_mul_b = 33'(i_cfg.gain);      end
            ST_AM: begin w_mul_a = {1'b0, r_amp};           w_mul_b = 33'(r_fac);           end
            default: begin w_mul_a = '0;                    w_mul_b = '0;                   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // ---- state register and regulator state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ci     <= '0;
            r_pi     <= '0;
            r_pcs    <= '0;
            r_pps    <= '0;
            r_el     <= '0;
            r_amp    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_MP: begin
                    r_ci  <= w_ci_sum[IW] ? '1 : w_ci_sum[IW-1:0];
                    r_pcs <= r_cs;
                end
                ST_ACC: begin
                    if (!r_sneg && (w_pi_add > P_MAX))     r_pi <= P_MAX[IW-1:0];
                    else if (r_sneg && (w_pi_add < P_MIN)) r_pi <= P_MIN[IW-1:0];
                    else                                   r_pi <= w_pi_add[IW-1:0];
                    r_pps <= r_ps;
                    if (r_first) r_amp <= i_cfg.init_amp;
                    r_el <= w_el_sum[DW] ? '1 : w_el_sum[DW-1:0];
                end
                ST_P3: begin
                    r_ci <= '0;
                    r_pi <= '0;
                    r_el <= '0;
                end
                ST_AM2: r_amp <= (r_prod[65:48] != '0) ? '1 : r_prod[47:16];
                default: ;
            endcase
            // output register
            if (w_emit)            r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    // ---- working registers ----
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_dt    <= i_item.time_step;
                r_cs    <= i_item.current_sq_sample;
                r_ps    <= i_item.power_sample;
                r_first <= i_item.first_step;
            end
            ST_MP:  r_sneg <= w_sp[DW];
            ST_CHK: begin
                r_done <= 1'b0;
                r_rms  <= '0;
                r_avg  <= '0;
            end
            ST_F0:  r_done <= 1'b1;
            ST_F1:  r_acc <= 96'(r_prod);
            ST_F2:  r_acc <= r_acc + {r_prod[63:0], 32'd0};
            ST_F3:  r_rms_sat <= (r_acc[95:64] != '0);
            ST_P1:  r_acc <= 96'(r_prod);
            ST_P2:  r_acc <= r_acc + {r_prod[63:0], 32'd0};
            ST_P3: begin
                if (r_pi[IW-1])
                    r_avg <= (w_m > 80'h8000_0000) ? 32'h8000_0000 : DW'(-w_m[DW-1:0]);
                else
                    r_avg <= (w_m > 80'h7FFF_FFFF) ? 32'h7FFF_FFFF : w_m[DW-1:0];
            end
            ST_SQW: r_rms <= r_rms_sat ? '1 : w_sq_root;
            ST_D0: begin
                r_e  <= w_e;
                r_ae <= w_e[DW] ? (DW+1)'(-w_e) : w_e;
            end
            ST_DIV: begin
                if (r_e[DW])
                    r_fac <= (w_quot >= QW'(C_HI - C_ONE)) ? 17'(C_HI)
                                                           : 17'(C_ONE) + w_quot[16:0];
                else
                    r_fac <= (w_quot >= QW'(C_ONE - C_LO)) ? 17'(C_LO)
                                                           : 17'(C_ONE) - w_quot[16:0];
            end
            default: ;
        endcase
        if (w_emit) begin
            r_o_amp  <= r_amp;
            r_o_done <= r_done;
            r_o_rms  <= r_rms;
            r_o_avg  <= r_avg;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_amplitude     = r_o_amp;
    assign o_period_done   = r_o_done;
    assign o_rms_current   = r_o_rms;
    assign o_average_power = $signed(r_o_avg);

    // ---- iterative units ----
    rcar_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (r_acc[63:0]),
        .o_busy     (w_sq_busy),
        .o_root     (w_sq_root)
    );

    rcar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod[QW-1:0]),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

endmodule

`default_nettype wire
